[rtl/core/sac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the set-associative cache tag array.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int unsigned REQ_TAG_W    = 20;
    localparam int unsigned SET_IDX_W    = 6;
    localparam int unsigned WAY_OUT_W    = 2;

    localparam int unsigned DEF_SETS     = 64;
    localparam int unsigned DEF_WAYS     = 4;
    localparam int unsigned DEF_TAG_BITS = 20;

    typedef struct packed {
        logic                  req_type;
        logic [REQ_TAG_W-1:0]  tag;
        logic [SET_IDX_W-1:0]  set_index;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [WAY_OUT_W-1:0]  way;
        logic                  writeback;
        logic [REQ_TAG_W-1:0]  victim_tag;
    } t_resp;

endpackage

[rtl/core/sac_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sac_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_lookup
// Way compare, fill selection, tree victim walk and set row update.
// ----------------------------------------------------------------------------
module sac_lookup #(
    parameter int unsigned WAYS     = 4,
    parameter int unsigned TAG_BITS = 20,
    parameter int unsigned WAY_W    = 2,
    parameter int unsigned NODES    = 3,
    parameter int unsigned META_W   = 11
) (
    input  logic                     i_wr,
    input  logic [TAG_BITS-1:0]      i_tag,
    input  logic [META_W-1:0]        i_meta,
    input  logic [WAYS*TAG_BITS-1:0] i_tags,
    output logic                     o_hit,
    output logic [WAY_W-1:0]         o_way,
    output logic                     o_writeback,
    output logic [TAG_BITS-1:0]      o_victim_tag,
    output logic [META_W-1:0]        o_meta,
    output logic [WAYS*TAG_BITS-1:0] o_tags
);

    logic [WAYS-1:0]   w_valid;
    logic [WAYS-1:0]   w_dirty;
    logic [NODES-1:0]  w_plru;
    logic [WAYS-1:0]   w_hit_vec;
    logic              w_hit;
    logic [WAY_W-1:0]  w_hit_way;
    logic              w_any_inv;
    logic [WAY_W-1:0]  w_inv_way;
    logic [WAY_W-1:0]  w_vic_way;
    logic [WAY_W-1:0]  w_sel;
    logic              w_vic_dirty;
    logic [TAG_BITS-1:0] w_vic_tag;
    logic [WAYS-1:0]   n_valid;
    logic [WAYS-1:0]   n_dirty;
    logic [NODES-1:0]  n_plru;

    assign w_valid = i_meta[WAYS-1:0];
    assign w_dirty = i_meta[2*WAYS-1:WAYS];
    assign w_plru  = i_meta[META_W-1:2*WAYS];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_hit_vec[w] = w_valid[w] && (i_tags[w*TAG_BITS +: TAG_BITS] == i_tag);
        end
    end

    always_comb begin
        w_hit     = 1'b0;
        w_hit_way = '0;
        w_any_inv = 1'b0;
        w_inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (!w_valid[w]) begin
                w_any_inv = 1'b1;
                w_inv_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        logic [WAY_W:0]   node;
        logic [WAY_W-1:0] vw;
        logic             b;
        node = '0;
        vw   = '0;
        for (int i = 0; i < WAY_W; i++) begin
            b    = w_plru[node[WAY_W-1:0]];
            vw   = WAY_W'({vw, b});
            node = (node << 1) + (WAY_W+1)'(1) + (WAY_W+1)'(b);
        end
        if ({1'b0, vw} >= (WAY_W+1)'(WAYS)) begin
            w_vic_way = WAY_W'(WAYS - 1);
        end else begin
            w_vic_way = vw;
        end
    end

    always_comb begin
        w_vic_dirty = 1'b0;
        w_vic_tag   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (w_vic_way == WAY_W'(w)) begin
                w_vic_dirty = w_dirty[w];
                w_vic_tag   = i_tags[w*TAG_BITS +: TAG_BITS];
            end
        end
    end

    assign w_sel        = w_hit ? w_hit_way : (w_any_inv ? w_inv_way : w_vic_way);
    assign o_hit        = w_hit;
    assign o_way        = w_sel;
    assign o_writeback  = !w_hit && !w_any_inv && w_vic_dirty;
    assign o_victim_tag = o_writeback ? w_vic_tag : '0;

    always_comb begin
        n_valid = w_valid;
        n_dirty = w_dirty;
        o_tags  = i_tags;
        for (int w = 0; w < WAYS; w++) begin
            if (w_sel == WAY_W'(w)) begin
                if (w_hit) begin
                    n_dirty[w] = w_dirty[w] | i_wr;
                end else begin
                    n_valid[w] = 1'b1;
                    n_dirty[w] = i_wr;
                    o_tags[w*TAG_BITS +: TAG_BITS] = i_tag;
                end
            end
        end
    end

    always_comb begin
        logic [WAY_W:0] node;
        logic           b;
        n_plru = w_plru;
        node   = '0;
        for (int i = WAY_W - 1; i >= 0; i--) begin
            b = w_sel[i];
            n_plru[node[WAY_W-1:0]] = ~b;
            node = (node << 1) + (WAY_W+1)'(1) + (WAY_W+1)'(b);
        end
    end

    assign o_meta = {n_plru, n_dirty, n_valid};

endmodule

[rtl/core/set_assoc_cache_tree_plru.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tree_plru
// Tag and state array of a set-associative write-back cache, tree PLRU.
// The set row is read at the request transfer; the response is registered
// from it in S_LOOK, later while the previous response still waits for its
// transfer. A new request is taken only after the update write, in S_IDLE.
// Reset: clears the valid, dirty and tree row of every set, one set per
// cycle, with request ready held low; tags are not cleared.
// ----------------------------------------------------------------------------
module set_assoc_cache_tree_plru #(
    parameter int unsigned SETS     = sac_pkg::DEF_SETS,
    parameter int unsigned WAYS     = sac_pkg::DEF_WAYS,
    parameter int unsigned TAG_BITS = sac_pkg::DEF_TAG_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sac_pkg::t_req i_req,
    output logic          o_resp_valid,
    input  logic          i_resp_ready,
    output sac_pkg::t_resp o_resp
);

    import sac_pkg::*;

    localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WAY_W  = $clog2(WAYS);
    localparam int unsigned NODES  = (1 << WAY_W) - 1;
    localparam int unsigned META_W = 2 * WAYS + NODES;
    localparam int unsigned TROW_W = WAYS * TAG_BITS;
    localparam int unsigned LUT_N  = 1 << SET_IDX_W;

    typedef enum logic [2:0] {
        S_CLR  = 3'b001,
        S_IDLE = 3'b010,
        S_LOOK = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SET_W-1:0]    r_clr;
    logic [SET_W-1:0]    r_set;
    logic                r_wr;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_out_vld;
    t_resp               r_resp;

    logic [SET_W-1:0]    w_set_lut [LUT_N];
    logic [TAG_BITS-1:0] w_in_tag;
    logic                w_accept;
    logic                w_done;
    logic [META_W-1:0]   w_meta_rd;
    logic [TROW_W-1:0]   w_tags_rd;
    logic                w_hit;
    logic [WAY_W-1:0]    w_way;
    logic                w_wb;
    logic [TAG_BITS-1:0] w_vtag;
    logic [META_W-1:0]   w_meta_wr;
    logic [TROW_W-1:0]   w_tags_wr;
    logic                w_meta_we;
    logic [SET_W-1:0]    w_meta_waddr;
    logic [META_W-1:0]   w_meta_wdata;
    logic [WAY_OUT_W-1:0]  w_way_out;
    logic [REQ_TAG_W-1:0]  w_vtag_out;

    genvar gi;
    generate
        for (gi = 0; gi < LUT_N; gi++) begin : g_set_lut
            localparam int unsigned SET_MOD = gi % SETS;
            assign w_set_lut[gi] = SET_W'(SET_MOD);
        end

        if (TAG_BITS > REQ_TAG_W) begin : g_tag_wide
            assign w_in_tag   = {{(TAG_BITS-REQ_TAG_W){1'b0}}, i_req.tag};
            assign w_vtag_out = w_vtag[REQ_TAG_W-1:0];
        end else if (TAG_BITS == REQ_TAG_W) begin : g_tag_same
            assign w_in_tag   = i_req.tag;
            assign w_vtag_out = w_vtag;
        end else begin : g_tag_narrow
            assign w_in_tag   = i_req.tag[TAG_BITS-1:0];
            assign w_vtag_out = {{(REQ_TAG_W-TAG_BITS){1'b0}}, w_vtag};
        end

        if (WAY_W >= WAY_OUT_W) begin : g_way_wide
            assign w_way_out = w_way[WAY_OUT_W-1:0];
        end else begin : g_way_narrow
            assign w_way_out = {{(WAY_OUT_W-WAY_W){1'b0}}, w_way};
        end
    endgenerate

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_done      = (r_state == S_LOOK) && (!r_out_vld || i_resp_ready);

    assign w_meta_we    = (r_state == S_CLR) || w_done;
    assign w_meta_waddr = (r_state == S_CLR) ? r_clr : r_set;
    assign w_meta_wdata = (r_state == S_CLR) ? '0 : w_meta_wr;

    sac_ram #(
        .WIDTH  (META_W),
        .DEPTH  (SETS),
        .ADDR_W (SET_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_re    (w_accept),
        .i_raddr (w_set_lut[i_req.set_index]),
        .o_rdata (w_meta_rd)
    );

    sac_ram #(
        .WIDTH  (TROW_W),
        .DEPTH  (SETS),
        .ADDR_W (SET_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_done && !w_hit),
        .i_waddr (r_set),
        .i_wdata (w_tags_wr),
        .i_re    (w_accept),
        .i_raddr (w_set_lut[i_req.set_index]),
        .o_rdata (w_tags_rd)
    );

    sac_lookup #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS),
        .WAY_W    (WAY_W),
        .NODES    (NODES),
        .META_W   (META_W)
    ) u_lookup (
        .i_wr         (r_wr),
        .i_tag        (r_tag),
        .i_meta       (w_meta_rd),
        .i_tags       (w_tags_rd),
        .o_hit        (w_hit),
        .o_way        (w_way),
        .o_writeback  (w_wb),
        .o_victim_tag (w_vtag),
        .o_meta       (w_meta_wr),
        .o_tags       (w_tags_wr)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (i_resp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= w_set_lut[i_req.set_index];
            r_wr  <= i_req.req_type;
            r_tag <= w_in_tag;
        end
        if (w_done) begin
            r_resp.hit        <= w_hit;
            r_resp.way        <= w_way_out;
            r_resp.writeback  <= w_wb;
            r_resp.victim_tag <= w_vtag_out;
        end
    end

    assign o_resp_valid = r_out_vld;
    assign o_resp       = r_resp;

endmodule
